// ===== hw/rtl/tip_force_setpoint_limiter_unit_defines.svh =====
// Assertion macros used by the tip force setpoint limiter checker.
`ifndef TIP_FORCE_SETPOINT_LIMITER_UNIT_DEFINES_SVH
`define TIP_FORCE_SETPOINT_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TFSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TFSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tfsl_pkg.sv =====
// Types, constants and helpers shared by the tip force setpoint limiter.
package tfsl_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [15:0] Q15_ONE = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_UP       = 3'd0,
    CFG_WEIGHT_DOWN     = 3'd1,
    CFG_DEADBAND        = 3'd2,
    CFG_FORCE_TARGET    = 3'd3,
    CFG_FORCE_EMERGENCY = 3'd4,
    CFG_EMERGENCY_RAISE = 3'd5,
    CFG_STEP_CAP        = 3'd6,
    CFG_TICK_PERIOD     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] weight_up;
    logic [15:0] weight_down;
    logic [22:0] deadband;
    logic [22:0] force_target;
    logic [22:0] force_emergency;
    logic [19:0] emergency_raise;
    logic [19:0] step_cap;
    logic [23:0] tick_period;
  } tfsl_cfg_t;

  localparam tfsl_cfg_t CFG_RESET = '{
    weight_up:       16'd16384,
    weight_down:     16'd1638,
    deadband:        23'd128,
    force_target:    23'd2560,
    force_emergency: 23'd5120,
    emergency_raise: 20'd1000,
    step_cap:        20'd200,
    tick_period:     24'd16777
  };

  typedef struct packed {
    logic               action;
    logic signed [23:0] force_raw;
    logic signed [31:0] current_setpoint;
    logic signed [31:0] new_goal;
    logic        [15:0] limit_gain;
  } tfsl_in_t;

  typedef struct packed {
    logic signed [31:0] setpoint_out;
    logic               goal_accepted;
    logic               emergency;
    logic               limiting;
    logic signed [23:0] filtered_force;
  } tfsl_out_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;
  } tfsl_mul_req_t;

  // base + inc, saturated to the 32 bit signed range.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                 input logic [19:0] inc);
    logic signed [32:0] sum;
    sum = $signed({base[31], base}) + $signed({13'b0, inc});
    if (sum[32] != sum[31]) begin
      sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = sum[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/tfsl_cfg.sv =====
// Configuration register file of the tip force setpoint limiter.
module tfsl_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tfsl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tfsl_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output tfsl_pkg::tfsl_cfg_t                  cfg_o
);
  import tfsl_pkg::*;

  tfsl_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT_UP:       cfg_q.weight_up       <= cfg_wdata_i[15:0];
        CFG_WEIGHT_DOWN:     cfg_q.weight_down     <= cfg_wdata_i[15:0];
        CFG_DEADBAND:        cfg_q.deadband        <= cfg_wdata_i[22:0];
        CFG_FORCE_TARGET:    cfg_q.force_target    <= cfg_wdata_i[22:0];
        CFG_FORCE_EMERGENCY: cfg_q.force_emergency <= cfg_wdata_i[22:0];
        CFG_EMERGENCY_RAISE: cfg_q.emergency_raise <= cfg_wdata_i[19:0];
        CFG_STEP_CAP:        cfg_q.step_cap        <= cfg_wdata_i[19:0];
        CFG_TICK_PERIOD:     cfg_q.tick_period     <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/tfsl_mul.sv =====
// Shared signed multiplier with a registered product.
module tfsl_mul (
  input  logic                                  clk_i,
  input  tfsl_pkg::tfsl_mul_req_t               req_i,
  output logic signed [tfsl_pkg::PROD_W-1:0]    prod_o
);
  import tfsl_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.op_a * req_i.op_b;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/tfsl_seq.sv =====
// Sequencer and datapath: filter, floor update and goal handling.
module tfsl_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tfsl_pkg::tfsl_cfg_t                cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tfsl_pkg::tfsl_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tfsl_pkg::tfsl_out_t                out_data_o,
  output tfsl_pkg::tfsl_mul_req_t            mul_req_o,
  input  logic signed [tfsl_pkg::PROD_W-1:0] mul_p_i
);
  import tfsl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_AX,
    ST_MUL_BO,
    ST_FILT,
    ST_DECIDE,
    ST_MUL_GE,
    ST_MUL_HT,
    ST_MUL_LT,
    ST_STEP,
    ST_LIMIT,
    ST_GOAL,
    ST_DONE
  } state_e;

  state_e             state_q;
  tfsl_in_t           in_q;
  logic signed [23:0] x_q;
  logic        [15:0] alpha_q;
  logic signed [23:0] filt_q;
  logic signed [31:0] floor_q;
  logic               floor_act_q;
  logic        [43:0] acc_q;
  logic        [19:0] lo_q;
  logic        [22:0] excess_q;
  logic        [19:0] step_q;
  tfsl_out_t          res_q;
  tfsl_out_t          out_q;
  logic               out_valid_q;
  logic               out_load;

  // deadband and weight select
  logic        [23:0] raw_mag;
  logic signed [23:0] x_c;
  logic        [15:0] a_sel;
  logic        [15:0] a_clamp;
  logic        [15:0] one_minus;

  // filter sum
  logic signed [41:0] filt_sum;
  logic signed [26:0] f_wide;
  logic signed [23:0] f_c;

  // decisions
  logic signed [24:0] f_ext;
  logic signed [24:0] tgt_ext;
  logic signed [24:0] emg_ext;
  logic signed [24:0] excess_wide;
  logic               limit_c;
  logic               emerg_c;
  logic signed [31:0] setp;
  logic signed [31:0] raise_sum;
  logic signed [31:0] hold_res;

  // rise step
  logic        [43:0] s_sum;
  logic        [31:0] s_shift;
  logic        [19:0] step_c;
  logic signed [31:0] cand;
  logic signed [31:0] new_floor;
  logic               goal_ok;

  always_comb begin
    raw_mag   = in_q.force_raw[23] ? 24'(-in_q.force_raw) : 24'(in_q.force_raw);
    x_c       = (raw_mag > {1'b0, cfg_i.deadband}) ? in_q.force_raw : 24'sd0;
    a_sel     = (x_c > filt_q) ? cfg_i.weight_up : cfg_i.weight_down;
    a_clamp   = (a_sel > Q15_ONE) ? Q15_ONE : a_sel;
    one_minus = Q15_ONE - alpha_q;

    // round to nearest, ties up, then floor shift
    filt_sum = $signed(acc_q[41:0]) + $signed(mul_p_i[41:0]) + 42'sd16384;
    f_wide   = filt_sum[41:15];
    if (f_wide > 27'sd8388607) begin
      f_c = 24'sh7f_ffff;
    end else if (f_wide < -27'sd8388608) begin
      f_c = 24'sh80_0000;
    end else begin
      f_c = f_wide[23:0];
    end

    setp        = in_q.current_setpoint;
    f_ext       = {filt_q[23], filt_q};
    tgt_ext     = $signed({2'b0, cfg_i.force_target});
    emg_ext     = $signed({2'b0, cfg_i.force_emergency});
    limit_c     = f_ext > tgt_ext;
    emerg_c     = f_ext > emg_ext;
    excess_wide = f_ext - tgt_ext;
    raise_sum   = sat_add(setp, cfg_i.emergency_raise);
    hold_res    = (floor_act_q && (floor_q > setp)) ? floor_q : setp;

    s_sum   = acc_q + {20'b0, mul_p_i[43:20]};
    s_shift = s_sum[43:12];
    step_c  = (s_shift < {12'b0, cfg_i.step_cap}) ? s_shift[19:0] : cfg_i.step_cap;

    cand      = sat_add(setp, step_q);
    new_floor = (!floor_act_q || (cand > floor_q)) ? cand : floor_q;

    goal_ok = (f_ext < tgt_ext) || (in_q.new_goal > setp);
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_req_o = '{en: 1'b0, op_a: '0, op_b: '0};
    case (state_q)
      ST_MUL_AX: begin
        mul_req_o.en   = 1'b1;
        mul_req_o.op_a = $signed({9'b0, alpha_q});
        mul_req_o.op_b = {x_q[23], x_q};
      end
      ST_MUL_BO: begin
        mul_req_o.en   = 1'b1;
        mul_req_o.op_a = $signed({9'b0, one_minus});
        mul_req_o.op_b = {filt_q[23], filt_q};
      end
      ST_MUL_GE: begin
        mul_req_o.en   = 1'b1;
        mul_req_o.op_a = $signed({9'b0, in_q.limit_gain});
        mul_req_o.op_b = $signed({2'b0, excess_q});
      end
      ST_MUL_HT: begin
        mul_req_o.en   = 1'b1;
        mul_req_o.op_a = $signed({6'b0, mul_p_i[38:20]});
        mul_req_o.op_b = $signed({1'b0, cfg_i.tick_period});
      end
      ST_MUL_LT: begin
        mul_req_o.en   = 1'b1;
        mul_req_o.op_a = $signed({5'b0, lo_q});
        mul_req_o.op_b = $signed({1'b0, cfg_i.tick_period});
      end
      default: ;
    endcase
  end

  // result moves to the output register once that register is free
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_q        <= '0;
      x_q         <= '0;
      alpha_q     <= '0;
      filt_q      <= '0;
      floor_q     <= '0;
      floor_act_q <= 1'b0;
      acc_q       <= '0;
      lo_q        <= '0;
      excess_q    <= '0;
      step_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= in_data_i.action ? ST_GOAL : ST_PREP;
          end
        end
        ST_PREP: begin
          x_q     <= x_c;
          alpha_q <= a_clamp;
          state_q <= ST_MUL_AX;
        end
        ST_MUL_AX: begin
          state_q <= ST_MUL_BO;
        end
        ST_MUL_BO: begin
          acc_q   <= {{2{mul_p_i[41]}}, mul_p_i[41:0]};
          state_q <= ST_FILT;
        end
        ST_FILT: begin
          filt_q  <= f_c;
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          res_q.goal_accepted  <= 1'b0;
          res_q.emergency      <= emerg_c;
          res_q.limiting       <= limit_c;
          res_q.filtered_force <= filt_q;
          excess_q             <= excess_wide[22:0];
          if (emerg_c) begin
            floor_q            <= raise_sum;
            floor_act_q        <= 1'b1;
            res_q.setpoint_out <= raise_sum;
            state_q            <= ST_DONE;
          end else if (limit_c) begin
            state_q <= ST_MUL_GE;
          end else begin
            res_q.setpoint_out <= hold_res;
            state_q            <= ST_DONE;
          end
        end
        ST_MUL_GE: begin
          state_q <= ST_MUL_HT;
        end
        ST_MUL_HT: begin
          // product is gain * excess; split at bit 20
          lo_q    <= mul_p_i[19:0];
          state_q <= ST_MUL_LT;
        end
        ST_MUL_LT: begin
          acc_q   <= mul_p_i[43:0];
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          step_q  <= step_c;
          state_q <= ST_LIMIT;
        end
        ST_LIMIT: begin
          floor_q            <= new_floor;
          floor_act_q        <= 1'b1;
          res_q.setpoint_out <= (new_floor > setp) ? new_floor : setp;
          state_q            <= ST_DONE;
        end
        ST_GOAL: begin
          res_q.emergency      <= 1'b0;
          res_q.limiting       <= 1'b0;
          res_q.goal_accepted  <= goal_ok;
          res_q.filtered_force <= filt_q;
          if (goal_ok) begin
            floor_act_q        <= 1'b0;
            floor_q            <= '0;
            res_q.setpoint_out <= in_q.new_goal;
          end else begin
            res_q.setpoint_out <= setp;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/tip_force_setpoint_limiter_unit.sv =====
// Tip force setpoint limiter: top level.
// Takes one item at a time; in_ready_o is low while an item is in work. A force
// sample with the filtered force at or below target, or above the emergency
// level, passes PREP, MUL_AX, MUL_BO, FILT and DECIDE; one raising the floor
// goes on via MUL_GE, MUL_HT, MUL_LT, STEP and LIMIT; a goal request passes GOAL.
// The single 25x25 multiplier is used in sequence for the two filter products
// and the three rise-step products, each product registered before it is used.
// The result sits in an output register, so the next item can be taken while
// a result waits for its output transfer. Configuration writes take effect on
// the next cycle and are meant to be made while the block is idle.
module tip_force_setpoint_limiter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tfsl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tfsl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tfsl_pkg::tfsl_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tfsl_pkg::tfsl_out_t             out_data_o
);
  import tfsl_pkg::*;

  tfsl_cfg_t                cfg;
  tfsl_mul_req_t            mul_req;
  logic signed [PROD_W-1:0] mul_p;

  tfsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tfsl_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  tfsl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mul_req_o   (mul_req),
    .mul_p_i     (mul_p)
  );

endmodule

// ===== hw/rtl/tfsl_checker.sv =====
// Port-level checker for the tip force setpoint limiter, with its bind.
`include "tip_force_setpoint_limiter_unit_defines.svh"

module tfsl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tfsl_pkg::tfsl_out_t out_data_o
);
  import tfsl_pkg::*;

  `TFSL_ASSERT_NXT(a_out_valid_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped before transfer")
  `TFSL_ASSERT_NXT(a_out_data_hold, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed while stalled")
  `TFSL_ASSERT_NXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "ready right after an input transfer")
  `TFSL_ASSERT_IMP(a_goal_flags, out_valid_o && out_data_o.goal_accepted, !out_data_o.emergency && !out_data_o.limiting, "goal result carries sample flags")

endmodule

bind tip_force_setpoint_limiter_unit tfsl_checker u_tfsl_checker (.*);
